/* src/rfgs_pkg.sv */
// Package for the rectangle-fill and glyph streamer.
// Holds the shared types, the command codes and the 5x7 font table.
// No dependencies.
package rfgs_pkg;

	localparam int unsigned DefPanelWidth  = 240;
	localparam int unsigned DefPanelHeight = 320;
	localparam int unsigned QueueDepth     = 2;

	localparam logic [7:0] CmdColumnSet = 8'h2a;
	localparam logic [7:0] CmdRowSet    = 8'h2b;
	localparam logic [7:0] CmdMemWrite  = 8'h2c;
	localparam logic [2:0] FontCols     = 3'd5;
	localparam logic [2:0] FontRows     = 3'd7;
	localparam logic [3:0] StepPixels   = 4'd11;
	localparam logic [3:0] StepCell     = 4'd15;

	typedef enum logic [1:0] {
		MODE_PULL  = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_GLYPH = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		OP_IDLE  = 2'd0,
		OP_FILL  = 2'd1,
		OP_GLYPH = 2'd2
	} op_t;

	typedef enum logic {
		BS_TAKE = 1'b0,
		BS_CELL = 1'b1
	} bstate_t;

	// one classified item as it waits for the back end
	typedef struct packed {
		mode_t       kind;
		logic        fill_ok;
		logic [15:0] x_pos;
		logic [15:0] y_pos;
		logic [15:0] rect_width;
		logic [15:0] rect_height;
		logic [15:0] color;
		logic [15:0] bg_color;
		logic [7:0]  scale;
		logic [7:0]  char_code;
		logic        first_char;
	} qentry_t;

	typedef struct packed {
		logic       full;
		logic       empty;
		logic [1:0] count;
	} qstat_t;

	// columns packed low to high: column 0 in bits 6:0
	function automatic logic [34:0] font_glyph(input logic [7:0] ch);
		logic [34:0] g;
		begin
			case (ch)
				8'h30: g = {7'h3e, 7'h45, 7'h49, 7'h51, 7'h3e};
				8'h31: g = {7'h00, 7'h40, 7'h7f, 7'h42, 7'h00};
				8'h32: g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
				8'h33: g = {7'h31, 7'h4b, 7'h45, 7'h41, 7'h21};
				8'h34: g = {7'h10, 7'h7f, 7'h12, 7'h14, 7'h18};
				8'h35: g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
				8'h36: g = {7'h30, 7'h49, 7'h49, 7'h4a, 7'h3c};
				8'h37: g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
				8'h38: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
				8'h39: g = {7'h1e, 7'h29, 7'h49, 7'h49, 7'h06};
				8'h41: g = {7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e};
				8'h42: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h7f};
				8'h43: g = {7'h22, 7'h41, 7'h41, 7'h41, 7'h3e};
				8'h44: g = {7'h1c, 7'h22, 7'h41, 7'h41, 7'h7f};
				8'h45: g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7f};
				8'h46: g = {7'h01, 7'h09, 7'h09, 7'h09, 7'h7f};
				8'h47: g = {7'h7a, 7'h49, 7'h49, 7'h41, 7'h3e};
				8'h48: g = {7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f};
				8'h49: g = {7'h00, 7'h41, 7'h7f, 7'h41, 7'h00};
				8'h4a: g = {7'h01, 7'h3f, 7'h41, 7'h40, 7'h20};
				8'h4b: g = {7'h41, 7'h22, 7'h14, 7'h08, 7'h7f};
				8'h4c: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7f};
				8'h4d: g = {7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f};
				8'h4e: g = {7'h7f, 7'h10, 7'h08, 7'h04, 7'h7f};
				8'h4f: g = {7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e};
				8'h50: g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7f};
				8'h51: g = {7'h5e, 7'h21, 7'h51, 7'h41, 7'h3e};
				8'h52: g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7f};
				8'h53: g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
				8'h54: g = {7'h01, 7'h01, 7'h7f, 7'h01, 7'h01};
				8'h55: g = {7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f};
				8'h56: g = {7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f};
				8'h57: g = {7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f};
				8'h58: g = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
				8'h59: g = {7'h07, 7'h08, 7'h70, 7'h08, 7'h07};
				8'h5a: g = {7'h43, 7'h45, 7'h49, 7'h51, 7'h61};
				8'h2d: g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
				8'h3a: g = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
				8'h2e: g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
				8'h5f: g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
				default: g = '0;
			endcase
			return g;
		end
	endfunction

endpackage

/* src/rfgs_if.sv */
// Channel interfaces for the streamer: command items in, link bytes out.
// Depends on nothing.
interface rfgs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [15:0] x_pos;
	logic [15:0] y_pos;
	logic [15:0] rect_width;
	logic [15:0] rect_height;
	logic [15:0] color;
	logic [15:0] bg_color;
	logic [7:0]  scale;
	logic [7:0]  char_code;
	logic        first_char;
	modport source (output valid, mode, x_pos, y_pos, rect_width, rect_height, color,
		bg_color, scale, char_code, first_char, input ready);
	modport sink (input valid, mode, x_pos, y_pos, rect_width, rect_height, color,
		bg_color, scale, char_code, first_char, output ready);
endinterface

interface rfgs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_command;
	logic       last;
	logic       error;
	modport source (output valid, out_byte, is_command, last, error, input ready);
	modport sink (input valid, out_byte, is_command, last, error, output ready);
endinterface

/* src/rect_fill_and_glyph_stream_top.sv */
// Rectangle fill and 5x7 glyph streamer for a panel link.
// in_ch carries command items: mode 1 starts a fill, mode 2 starts a glyph,
// mode 0 pulls the next link byte; mode 3 is taken and ignored.
// out_ch carries one byte per pull (out_byte, is_command, last, error);
// starts give a result only when rejected (error set, byte zero).
// A pull while idle gives nothing.
// An accepted item is written into a two-entry queue, from which the back end
// takes it; its byte is registered and shows on out_ch the next cycle.
// A pull that opens a glyph cell passes through the cell state for the cell
// offset multiply. Throughput is one item per cycle when out_ch does not stall;
// the cell state holds back the next item. When out_ch stalls, the output
// register holds, the queue fills and in_ch ready falls after two more items.
// Reset empties the queue and clears the output valid flag and the stream state.
// Depends on rfgs_pkg, rfgs_if, rfgs_front, rfgs_queue and rfgs_back.
module rect_fill_and_glyph_stream_top import rfgs_pkg::*; #(
	parameter int unsigned PANEL_WIDTH  = DefPanelWidth,
	parameter int unsigned PANEL_HEIGHT = DefPanelHeight
) (
	input  logic clk,
	input  logic arst_n,
	rfgs_in_if.sink    in_ch,
	rfgs_out_if.source out_ch
);
	qentry_t push_data, pop_data;
	qstat_t  qstat;
	logic    push, pop;

	rfgs_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
		.in_ch  (in_ch),
		.q_full (qstat.full),
		.q_push (push),
		.q_data (push_data)
	);

	rfgs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	rfgs_back #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (pop_data),
		.q_empty (qstat.empty),
		.q_pop   (pop),
		.out_ch  (out_ch)
	);

`ifndef SYNTH
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= 2'(QueueDepth))
		else $error("queue count out of range");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !in_ch.ready)
		else $error("ready high with queue full");
	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.error |-> out_ch.out_byte == '0 && !out_ch.last
			&& !out_ch.is_command)
		else $error("malformed error item");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");
`endif
endmodule

/* src/rfgs_front.sv */
// Front end: takes command items, classifies them and checks fill bounds.
// Depends on rfgs_pkg and rfgs_in_if.
module rfgs_front import rfgs_pkg::*; #(
	parameter int unsigned PANEL_WIDTH  = DefPanelWidth,
	parameter int unsigned PANEL_HEIGHT = DefPanelHeight
) (
	rfgs_in_if.sink in_ch,
	input  logic    q_full,
	output logic    q_push,
	output qentry_t q_data
);
	localparam logic [16:0] PwLim = 17'(PANEL_WIDTH);
	localparam logic [16:0] PhLim = 17'(PANEL_HEIGHT);

	logic [16:0] x_end, y_end;

	assign in_ch.ready = !q_full;
	assign x_end = {1'b0, in_ch.x_pos} + {1'b0, in_ch.rect_width};
	assign y_end = {1'b0, in_ch.y_pos} + {1'b0, in_ch.rect_height};

	// unused mode is accepted and dropped here
	assign q_push = in_ch.valid && !q_full && (mode_t'(in_ch.mode) != MODE_NONE);

	always_comb begin
		q_data.kind        = mode_t'(in_ch.mode);
		q_data.fill_ok     = (in_ch.rect_width != '0) && (in_ch.rect_height != '0)
			&& (x_end <= PwLim) && (y_end <= PhLim);
		q_data.x_pos       = in_ch.x_pos;
		q_data.y_pos       = in_ch.y_pos;
		q_data.rect_width  = in_ch.rect_width;
		q_data.rect_height = in_ch.rect_height;
		q_data.color       = in_ch.color;
		q_data.bg_color    = in_ch.bg_color;
		q_data.scale       = in_ch.scale;
		q_data.char_code   = in_ch.char_code;
		q_data.first_char  = in_ch.first_char;
	end
endmodule

/* src/rfgs_queue.sv */
// Short item queue between front and back end.
// Depends on rfgs_pkg.
module rfgs_queue import rfgs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  qentry_t push_data,
	input  logic    pop,
	output qentry_t pop_data,
	output qstat_t  stat
);
	qentry_t    mem_q [QueueDepth];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign stat.count = cnt_q;
	assign stat.full  = (cnt_q == 2'(QueueDepth));
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* src/rfgs_back.sv */
// Back end: runs fill and glyph streams and registers each link byte.
// Depends on rfgs_pkg and rfgs_out_if.
module rfgs_back import rfgs_pkg::*; #(
	parameter int unsigned PANEL_WIDTH  = DefPanelWidth,
	parameter int unsigned PANEL_HEIGHT = DefPanelHeight
) (
	input  logic    clk,
	input  logic    arst_n,
	input  qentry_t q_data,
	input  logic    q_empty,
	output logic    q_pop,
	rfgs_out_if.source out_ch
);
	localparam logic [16:0] PwLim = 17'(PANEL_WIDTH);
	localparam logic [16:0] PhLim = 17'(PANEL_HEIGHT);

	bstate_t     bst_q, bst_d;
	op_t         op_q, op_d;
	logic [3:0]  step_q, step_d;
	logic [15:0] wx0_q, wy0_q, wx1_q, wy1_q, wx0_d, wy0_d, wx1_d, wy1_d;
	logic [31:0] pix_q, pix_d;
	logic        phase_q, phase_d;
	logic [15:0] pcol_q, pcol_d, fg_q, fg_d, bg_q, bg_d;
	logic [7:0]  sc_q, sc_d, ch_q, ch_d;
	logic [2:0]  col_q, col_d, row_q, row_d;
	logic [15:0] ox_q, ox_d, oy_q, oy_d, cidx_q, cidx_d;
	logic [15:0] mx_q, my_q;
	logic        ov_q, ov_d, ocmd_q, ocmd_d, olast_q, olast_d, oerr_q, oerr_d;
	logic [7:0]  obyte_q, obyte_d;

	logic        out_free, is_pull, cell_pend, take, emit;
	logic [15:0] cell_base, px, py;
	logic [16:0] px_end, py_end;
	logic [34:0] gbits;
	logic [6:0]  gcol;
	logic        cell_on, cell_ok;
	logic [2:0]  row_inc;

	assign out_free  = !ov_q || out_ch.ready;
	assign is_pull   = (q_data.kind == MODE_PULL);
	assign cell_pend = (op_q == OP_GLYPH) && (step_q == StepCell);
	assign take      = (bst_q == BS_TAKE) && !q_empty && out_free;
	assign q_pop     = take;

	assign cell_base = 16'((cidx_q << 2) + (cidx_q << 1)) + 16'(col_q);
	assign px        = ox_q + mx_q;
	assign py        = oy_q + my_q;
	assign px_end    = {1'b0, px} + 17'(sc_q);
	assign py_end    = {1'b0, py} + 17'(sc_q);
	assign cell_ok   = (px_end <= PwLim) && (py_end <= PhLim);
	assign gbits     = font_glyph(ch_q);
	assign gcol      = gbits[7*col_q +: 7];
	assign cell_on   = gcol[row_q];
	assign row_inc   = row_q + 3'd1;

	assign out_ch.valid      = ov_q;
	assign out_ch.out_byte   = obyte_q;
	assign out_ch.is_command = ocmd_q;
	assign out_ch.last       = olast_q;
	assign out_ch.error      = oerr_q;

	// next state
	always_comb begin
		bst_d = bst_q;
		unique case (bst_q)
			BS_TAKE: begin
				if (take && is_pull && cell_pend) begin
					bst_d = BS_CELL;
				end
			end
			BS_CELL: begin
				if (out_free) begin
					bst_d = BS_TAKE;
				end
			end
			default: bst_d = BS_TAKE;
		endcase
	end

	// datapath and result byte
	always_comb begin
		op_d = op_q; step_d = step_q; pix_d = pix_q; phase_d = phase_q;
		wx0_d = wx0_q; wy0_d = wy0_q; wx1_d = wx1_q; wy1_d = wy1_q;
		pcol_d = pcol_q; fg_d = fg_q; bg_d = bg_q; sc_d = sc_q; ch_d = ch_q;
		col_d = col_q; row_d = row_q; ox_d = ox_q; oy_d = oy_q; cidx_d = cidx_q;
		ov_d = ov_q && !out_ch.ready;
		obyte_d = obyte_q; ocmd_d = ocmd_q; olast_d = olast_q; oerr_d = oerr_q;
		emit = 1'b0;

		if (bst_q == BS_CELL && out_free) begin
			if (!cell_ok) begin
				op_d = OP_IDLE; step_d = '0; phase_d = 1'b0; pix_d = '0;
				ov_d = 1'b1; obyte_d = '0; ocmd_d = 1'b0; olast_d = 1'b0; oerr_d = 1'b1;
			end else begin
				wx0_d = px; wy0_d = py;
				wx1_d = 16'(px_end - 17'd1);
				wy1_d = 16'(py_end - 17'd1);
				pix_d = 32'(16'(sc_q) * 16'(sc_q));
				pcol_d = cell_on ? fg_q : bg_q;
				phase_d = 1'b0;
				step_d = 4'd1;
				ov_d = 1'b1; obyte_d = CmdColumnSet; ocmd_d = 1'b1;
				olast_d = 1'b0; oerr_d = 1'b0;
			end
		end else if (take) begin
			case (q_data.kind)
				MODE_FILL: begin
					op_d = OP_IDLE; step_d = '0; phase_d = 1'b0; pix_d = '0;
					if (!q_data.fill_ok) begin
						ov_d = 1'b1; obyte_d = '0; ocmd_d = 1'b0; olast_d = 1'b0; oerr_d = 1'b1;
					end else begin
						wx0_d = q_data.x_pos; wy0_d = q_data.y_pos;
						wx1_d = q_data.x_pos + q_data.rect_width - 16'd1;
						wy1_d = q_data.y_pos + q_data.rect_height - 16'd1;
						pix_d = q_data.rect_width * q_data.rect_height;
						pcol_d = q_data.color;
						op_d = OP_FILL;
					end
				end
				MODE_GLYPH: begin
					op_d = OP_IDLE; step_d = '0; phase_d = 1'b0; pix_d = '0;
					if (q_data.first_char) begin
						cidx_d = '0; ox_d = q_data.x_pos; oy_d = q_data.y_pos;
					end else begin
						cidx_d = cidx_q + 16'd1;
					end
					if (q_data.scale == '0) begin
						ov_d = 1'b1; obyte_d = '0; ocmd_d = 1'b0; olast_d = 1'b0; oerr_d = 1'b1;
					end else begin
						fg_d = q_data.color; bg_d = q_data.bg_color;
						sc_d = q_data.scale; ch_d = q_data.char_code;
						col_d = '0; row_d = '0; step_d = StepCell; op_d = OP_GLYPH;
					end
				end
				MODE_PULL: begin
					// a pending glyph cell is handled in the cell state
					emit = (op_q != OP_IDLE) && !cell_pend;
				end
				default: ;
			endcase
		end

		if (emit) begin
			ov_d = 1'b1; ocmd_d = 1'b0; olast_d = 1'b0; oerr_d = 1'b0;
			step_d = step_q + 4'd1;
			case (step_q)
				4'd0:  begin obyte_d = CmdColumnSet; ocmd_d = 1'b1; end
				4'd1:  obyte_d = wx0_q[15:8];
				4'd2:  obyte_d = wx0_q[7:0];
				4'd3:  obyte_d = wx1_q[15:8];
				4'd4:  obyte_d = wx1_q[7:0];
				4'd5:  begin obyte_d = CmdRowSet; ocmd_d = 1'b1; end
				4'd6:  obyte_d = wy0_q[15:8];
				4'd7:  obyte_d = wy0_q[7:0];
				4'd8:  obyte_d = wy1_q[15:8];
				4'd9:  obyte_d = wy1_q[7:0];
				4'd10: begin obyte_d = CmdMemWrite; ocmd_d = 1'b1; end
				default: begin
					step_d = step_q;
					if (!phase_q) begin
						phase_d = 1'b1;
						obyte_d = pcol_q[15:8];
					end else begin
						phase_d = 1'b0;
						obyte_d = pcol_q[7:0];
						pix_d = pix_q - 32'd1;
						if (pix_q == 32'd1) begin
							if (op_q == OP_FILL) begin
								olast_d = 1'b1;
								op_d = OP_IDLE; step_d = '0; pix_d = '0;
							end else if (row_inc >= FontRows) begin
								row_d = '0;
								if (col_q + 3'd1 >= FontCols) begin
									col_d = '0; olast_d = 1'b1;
									op_d = OP_IDLE; step_d = '0; pix_d = '0;
								end else begin
									col_d = col_q + 3'd1;
									step_d = StepCell;
								end
							end else begin
								row_d = row_inc;
								step_d = StepCell;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mx_q <= 16'(cell_base * sc_q);
			my_q <= 16'(row_q) * 16'(sc_q);
		end
		obyte_q <= obyte_d;
		ocmd_q  <= ocmd_d;
		olast_q <= olast_d;
		oerr_q  <= oerr_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= BS_TAKE; op_q <= OP_IDLE; step_q <= '0; pix_q <= '0; phase_q <= 1'b0;
			wx0_q <= '0; wy0_q <= '0; wx1_q <= '0; wy1_q <= '0;
			pcol_q <= '0; fg_q <= '0; bg_q <= '0; sc_q <= '0; ch_q <= '0;
			col_q <= '0; row_q <= '0; ox_q <= '0; oy_q <= '0; cidx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			bst_q <= bst_d; op_q <= op_d; step_q <= step_d; pix_q <= pix_d;
			phase_q <= phase_d;
			wx0_q <= wx0_d; wy0_q <= wy0_d; wx1_q <= wx1_d; wy1_q <= wy1_d;
			pcol_q <= pcol_d; fg_q <= fg_d; bg_q <= bg_d; sc_q <= sc_d; ch_q <= ch_d;
			col_q <= col_d; row_q <= row_d; ox_q <= ox_d; oy_q <= oy_d; cidx_q <= cidx_d;
			ov_q <= ov_d;
		end
	end
endmodule
